>>> src/bmhq_pkg.sv
`timescale 1ns / 1ps

package bmhq_pkg;

  // operation codes of an input word
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int UPC_BITS = 4;

  // microprogram step addresses
  localparam logic [UPC_BITS-1:0] S_WAIT       = 4'd0;
  localparam logic [UPC_BITS-1:0] S_DISPATCH   = 4'd1;
  localparam logic [UPC_BITS-1:0] S_PUSH_CHK   = 4'd2;
  localparam logic [UPC_BITS-1:0] S_PUSH_INIT  = 4'd3;
  localparam logic [UPC_BITS-1:0] S_UP_RD      = 4'd4;
  localparam logic [UPC_BITS-1:0] S_UP_CMP     = 4'd5;
  localparam logic [UPC_BITS-1:0] S_UP_PLACE   = 4'd6;
  localparam logic [UPC_BITS-1:0] S_POP_CHK    = 4'd7;
  localparam logic [UPC_BITS-1:0] S_POP_TAKE   = 4'd8;
  localparam logic [UPC_BITS-1:0] S_DN_RD      = 4'd9;
  localparam logic [UPC_BITS-1:0] S_DN_CMP     = 4'd10;
  localparam logic [UPC_BITS-1:0] S_DN_PLACE   = 4'd11;
  localparam logic [UPC_BITS-1:0] S_EMIT_OK    = 4'd12;
  localparam logic [UPC_BITS-1:0] S_EMIT_FULL  = 4'd13;
  localparam logic [UPC_BITS-1:0] S_EMIT_EMPTY = 4'd14;

  typedef enum logic [3:0] {
    A_NONE,
    A_ACCEPT,
    A_PUSH_INIT,
    A_UP_READ,
    A_UP_STEP,
    A_PLACE,
    A_POP_READ,
    A_POP_TAKE,
    A_DN_READ,
    A_DN_STEP,
    A_EMIT_OK,
    A_EMIT_EMPTY,
    A_EMIT_FULL
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_POP,
    C_FULL,
    C_ROOT,
    C_UP_MOVE,
    C_EMPTY,
    C_LAST,
    C_LEAF,
    C_DN_MOVE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    act_e                act;
    cond_e               cond;
    logic [UPC_BITS-1:0] target;
    logic                done;    // fall through to S_WAIT instead of the next step
  } ucw_t;

  typedef struct packed {
    logic accepted;
    logic is_pop;
    logic full;
    logic root;
    logic up_move;
    logic empty;
    logic last;
    logic leaf;
    logic dn_move;
    logic out_busy;
  } flags_t;

  function automatic ucw_t ucw(input act_e a, input cond_e c,
                               input logic [UPC_BITS-1:0] t, input logic d);
    ucw_t w;
    w.act    = a;
    w.cond   = c;
    w.target = t;
    w.done   = d;
    return w;
  endfunction

  // control store
  function automatic ucw_t ucode_rom(input logic [UPC_BITS-1:0] addr);
    ucw_t w;
    case (addr)
      S_WAIT:       w = ucw(A_ACCEPT,     C_NO_IN,    S_WAIT,       1'b0);
      S_DISPATCH:   w = ucw(A_NONE,       C_POP,      S_POP_CHK,    1'b0);
      S_PUSH_CHK:   w = ucw(A_NONE,       C_FULL,     S_EMIT_FULL,  1'b0);
      S_PUSH_INIT:  w = ucw(A_PUSH_INIT,  C_NEVER,    S_WAIT,       1'b0);
      S_UP_RD:      w = ucw(A_UP_READ,    C_ROOT,     S_UP_PLACE,   1'b0);
      S_UP_CMP:     w = ucw(A_UP_STEP,    C_UP_MOVE,  S_UP_RD,      1'b0);
      S_UP_PLACE:   w = ucw(A_PLACE,      C_ALWAYS,   S_EMIT_OK,    1'b0);
      S_POP_CHK:    w = ucw(A_POP_READ,   C_EMPTY,    S_EMIT_EMPTY, 1'b0);
      S_POP_TAKE:   w = ucw(A_POP_TAKE,   C_LAST,     S_EMIT_OK,    1'b0);
      S_DN_RD:      w = ucw(A_DN_READ,    C_LEAF,     S_DN_PLACE,   1'b0);
      S_DN_CMP:     w = ucw(A_DN_STEP,    C_DN_MOVE,  S_DN_RD,      1'b0);
      S_DN_PLACE:   w = ucw(A_PLACE,      C_ALWAYS,   S_EMIT_OK,    1'b0);
      S_EMIT_OK:    w = ucw(A_EMIT_OK,    C_OUT_BUSY, S_EMIT_OK,    1'b1);
      S_EMIT_FULL:  w = ucw(A_EMIT_FULL,  C_OUT_BUSY, S_EMIT_FULL,  1'b1);
      S_EMIT_EMPTY: w = ucw(A_EMIT_EMPTY, C_OUT_BUSY, S_EMIT_EMPTY, 1'b1);
      default:      w = ucw(A_NONE,       C_ALWAYS,   S_WAIT,       1'b0);
    endcase
    return w;
  endfunction

endpackage

>>> src/bmhq_if.sv
`timescale 1ns / 1ps

interface bmhq_in_if #(
  parameter int KEY_BITS = 8,
  parameter int TAG_BITS = 16
);
  logic                valid;
  logic                ready;
  logic                kind;
  logic [KEY_BITS-1:0] entry_key;
  logic [TAG_BITS-1:0] entry_tag;

  modport source (output valid, kind, entry_key, entry_tag, input ready);
  modport sink   (input valid, kind, entry_key, entry_tag, output ready);
endinterface

interface bmhq_out_if #(
  parameter int KEY_BITS = 8,
  parameter int TAG_BITS = 16,
  parameter int OCC_BITS = 7
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [KEY_BITS-1:0] popped_key;
  logic [TAG_BITS-1:0] popped_tag;
  logic [OCC_BITS-1:0] occupancy;

  modport source (output valid, status, popped_key, popped_tag, occupancy, input ready);
  modport sink   (input valid, status, popped_key, popped_tag, occupancy, output ready);
endinterface

>>> src/binary_min_heap_queue_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Word fields                                     Handshake
// in_i     in   kind, entry_key, entry_tag                      valid/ready
// out_o    out  status, popped_key, popped_tag, occupancy       valid/ready
//
// Push: the new entry moves up level by level until it reaches the root or a
// compare stops it; pop likewise moves down to a leaf or until a compare stops it.
// Each level is one heap read plus one compare-and-write step. A refused push, an
// empty pop and a last-entry pop go straight to their result with no heap walk.
// Reset clears the entry count and the step counter; no clearing pass.
// A new word is taken while the previous result still waits in the output
// register; the sequencer stalls only when it must emit into a full register.
module binary_min_heap_queue_top #(
  parameter int HEAP_DEPTH = 64,
  parameter int KEY_BITS   = 8,
  parameter int TAG_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmhq_in_if.sink    in_i,
  bmhq_out_if.source out_o
);
  import bmhq_pkg::*;

  ucw_t   ctrl;
  flags_t flags;

  bmhq_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  bmhq_dpath #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .flags_o (flags),
    .in_i    (in_i),
    .out_o   (out_o)
  );

endmodule

>>> src/bmhq_seq.sv
`timescale 1ns / 1ps

module bmhq_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bmhq_pkg::flags_t flags_i,
  output bmhq_pkg::ucw_t   ctrl_o
);
  import bmhq_pkg::*;

  logic [UPC_BITS-1:0] upc_q, upc_d;
  ucw_t                word;
  logic                take;

  assign word   = ucode_rom(upc_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !flags_i.accepted;
      C_POP:      take = flags_i.is_pop;
      C_FULL:     take = flags_i.full;
      C_ROOT:     take = flags_i.root;
      C_UP_MOVE:  take = flags_i.up_move;
      C_EMPTY:    take = flags_i.empty;
      C_LAST:     take = flags_i.last;
      C_LEAF:     take = flags_i.leaf;
      C_DN_MOVE:  take = flags_i.dn_move;
      C_OUT_BUSY: take = flags_i.out_busy;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      upc_d = word.target;
    end else if (word.done) begin
      upc_d = S_WAIT;
    end else begin
      upc_d = upc_q + UPC_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> src/bmhq_dpath.sv
`timescale 1ns / 1ps

module bmhq_dpath #(
  parameter int HEAP_DEPTH = 64,
  parameter int KEY_BITS   = 8,
  parameter int TAG_BITS   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bmhq_pkg::ucw_t   ctrl_i,
  output bmhq_pkg::flags_t flags_o,
  bmhq_in_if.sink          in_i,
  bmhq_out_if.source       out_o
);
  import bmhq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int EW = KEY_BITS + TAG_BITS;
  localparam int XW = AW + 2;

  logic [EW-1:0]       mem_q [HEAP_DEPTH];
  logic [EW-1:0]       rd_a_q, rd_b_q, cur_q;
  logic [AW-1:0]       pos_q;
  logic [CW-1:0]       count_q;
  logic                kind_q;
  logic [KEY_BITS-1:0] pkey_q;
  logic [TAG_BITS-1:0] ptag_q;

  logic                out_valid_q;
  logic [1:0]          out_status_q;
  logic [KEY_BITS-1:0] out_key_q;
  logic [TAG_BITS-1:0] out_tag_q;
  logic [CW-1:0]       out_occ_q;

  logic [AW-1:0]       rd_a_addr, rd_b_addr, parent, best_addr;
  logic [XW-1:0]       left_x, right_x, count_x;
  logic [CW-1:0]       count_m1;
  logic [KEY_BITS-1:0] cur_key, a_key, b_key;
  logic                left_lt, right_lt, up_move, dn_move;
  logic [EW-1:0]       best_data, wr_data;
  logic                wr_en, accepted, out_busy, emit;
  logic [1:0]          emit_status;

  assign cur_key  = cur_q[EW-1 -: KEY_BITS];
  assign a_key    = rd_a_q[EW-1 -: KEY_BITS];
  assign b_key    = rd_b_q[EW-1 -: KEY_BITS];

  assign left_x   = {1'b0, pos_q, 1'b1};
  assign right_x  = {1'b0, pos_q, 1'b0} + XW'(2);
  assign count_x  = XW'(count_q);
  assign count_m1 = count_q - CW'(1);
  assign parent   = (pos_q - AW'(1)) >> 1;

  // strict compares: equal keys never move
  assign up_move   = a_key > cur_key;
  assign left_lt   = a_key < cur_key;
  assign right_lt  = (right_x < count_x) && (b_key < (left_lt ? a_key : cur_key));
  assign dn_move   = left_lt || right_lt;
  assign best_data = right_lt ? rd_b_q : rd_a_q;
  assign best_addr = right_lt ? right_x[AW-1:0] : left_x[AW-1:0];

  assign in_i.ready = (ctrl_i.act == A_ACCEPT);
  assign accepted   = in_i.valid && in_i.ready;
  assign out_busy   = out_valid_q && !out_o.ready;

  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = '0;
    case (ctrl_i.act)
      A_UP_READ: begin
        rd_a_addr = parent;
      end
      A_POP_READ: begin
        rd_b_addr = count_m1[AW-1:0];
      end
      A_DN_READ: begin
        rd_a_addr = left_x[AW-1:0];
        rd_b_addr = right_x[AW-1:0];
      end
      default: begin
        rd_a_addr = '0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = cur_q;
    case (ctrl_i.act)
      A_UP_STEP: begin
        wr_en   = up_move;
        wr_data = rd_a_q;
      end
      A_DN_STEP: begin
        wr_en   = dn_move;
        wr_data = best_data;
      end
      A_PLACE: begin
        wr_en   = 1'b1;
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    case (ctrl_i.act)
      A_EMIT_OK: begin
        emit        = 1'b1;
      end
      A_EMIT_EMPTY: begin
        emit        = 1'b1;
        emit_status = ST_EMPTY;
      end
      A_EMIT_FULL: begin
        emit        = 1'b1;
        emit_status = ST_FULL;
      end
      default: begin
        emit        = 1'b0;
      end
    endcase
  end

  // heap store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[pos_q] <= wr_data;
    end
    rd_a_q <= mem_q[rd_a_addr];
    rd_b_q <= mem_q[rd_b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      kind_q      <= KIND_PUSH;
      out_valid_q <= 1'b0;
    end else begin
      if (accepted) begin
        kind_q <= in_i.kind;
      end
      case (ctrl_i.act)
        A_PUSH_INIT: begin
          pos_q   <= count_q[AW-1:0];
          count_q <= count_q + CW'(1);
        end
        A_UP_STEP: begin
          if (up_move) begin
            pos_q <= parent;
          end
        end
        A_POP_TAKE: begin
          pos_q   <= '0;
          count_q <= count_m1;
        end
        A_DN_STEP: begin
          if (dn_move) begin
            pos_q <= best_addr;
          end
        end
        default: begin
          pos_q <= pos_q;
        end
      endcase
      if (emit && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accepted) begin
      cur_q  <= {in_i.entry_key, in_i.entry_tag};
      pkey_q <= '0;
      ptag_q <= '0;
    end
    if (ctrl_i.act == A_POP_TAKE) begin
      // hold the root for the result, take the last entry as the hole filler
      pkey_q <= rd_a_q[EW-1 -: KEY_BITS];
      ptag_q <= rd_a_q[TAG_BITS-1:0];
      cur_q  <= rd_b_q;
    end
    if (emit && !out_busy) begin
      out_status_q <= emit_status;
      out_key_q    <= pkey_q;
      out_tag_q    <= ptag_q;
      out_occ_q    <= count_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.popped_key = out_key_q;
  assign out_o.popped_tag = out_tag_q;
  assign out_o.occupancy  = out_occ_q;

  assign flags_o.accepted = accepted;
  assign flags_o.is_pop   = (kind_q == KIND_POP);
  assign flags_o.full     = (count_q == CW'(HEAP_DEPTH));
  assign flags_o.root     = (pos_q == '0);
  assign flags_o.up_move  = up_move;
  assign flags_o.empty    = (count_q == '0);
  assign flags_o.last     = (count_q == CW'(1));
  assign flags_o.leaf     = (left_x >= count_x);
  assign flags_o.dn_move  = dn_move;
  assign flags_o.out_busy = out_busy;

endmodule

>>> src/bmhq_checker.sv
`timescale 1ns / 1ps

module bmhq_checker #(
  parameter int HEAP_DEPTH = 64,
  parameter int KEY_BITS   = 8,
  parameter int TAG_BITS   = 16,
  parameter int CW         = 7
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [1:0]          out_status_i,
  input logic [KEY_BITS-1:0] out_popped_key_i,
  input logic [TAG_BITS-1:0] out_popped_tag_i,
  input logic [CW-1:0]       out_occupancy_i
);
  import bmhq_pkg::*;

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_word_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_status_i) && $stable(out_occupancy_i)
      && $stable(out_popped_key_i) && $stable(out_popped_tag_i))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i == ST_OK || out_status_i == ST_EMPTY
      || out_status_i == ST_FULL)
    else $error("undefined status code");

  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_popped_key_i == '0
      && out_popped_tag_i == '0)
    else $error("popped fields set on a failed operation");

  a_occ_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i != ST_EMPTY || out_occupancy_i == '0)
      && (out_status_i != ST_FULL || out_occupancy_i == CW'(HEAP_DEPTH)))
    else $error("occupancy disagrees with status");

endmodule

bind binary_min_heap_queue_top bmhq_checker #(
  .HEAP_DEPTH (HEAP_DEPTH),
  .KEY_BITS   (KEY_BITS),
  .TAG_BITS   (TAG_BITS),
  .CW         ($clog2(HEAP_DEPTH + 1))
) u_bmhq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_status_i     (out_o.status),
  .out_popped_key_i (out_o.popped_key),
  .out_popped_tag_i (out_o.popped_tag),
  .out_occupancy_i  (out_o.occupancy)
);
